>>> hdl/sps_pkg.sv
// Shared types, constants and the coil pattern table for the stepper phase sequencer.
package sps_pkg;

    localparam int PERIOD_W = 19;
    localparam int STEPS_W  = 13;
    localparam int CMD_W    = 3;
    localparam int PAT_W    = 3;
    localparam int PHASE_W  = 3;
    localparam int COILS_W  = 4;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST = 19'd300;
    localparam logic [PERIOD_W-1:0] MAX_PERIOD_RST = 19'd500000;
    localparam logic [STEPS_W-1:0]  COUNTDOWN_RST  = 13'd4075;

    // floor(p*5/6) = (p * FAST_MUL) >> MUL_SHIFT, floor(p*6/5) = (p * SLOW_MUL) >> MUL_SHIFT
    localparam int MUL_SHIFT = 25;
    localparam int FAST_MUL_W = 25;
    localparam int SLOW_MUL_W = 26;
    localparam logic [FAST_MUL_W-1:0] FAST_MUL = 25'd27962030;
    localparam logic [SLOW_MUL_W-1:0] SLOW_MUL = 26'd40265322;

    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SELECT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FASTER  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SLOWER  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ARM     = 3'd5;
    localparam logic [CMD_W-1:0] CMD_STOP    = 3'd6;

    localparam logic [PAT_W-1:0] PAT_OFF  = 3'd0;
    localparam logic [PAT_W-1:0] PAT_FULL = 3'd1;
    localparam logic [PAT_W-1:0] PAT_HALF = 3'd2;
    localparam logic [PAT_W-1:0] PAT_WAVE = 3'd3;
    localparam logic [PAT_W-1:0] PAT_GAP  = 3'd4;

    localparam logic [REG_IDX_W-1:0] REG_MIN_PERIOD = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_PERIOD = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COUNTDOWN  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [PAT_W-1:0] pattern_select;
    } cmd_beat_t;

    typedef struct packed {
        logic [COILS_W-1:0]  coils;
        logic                stepped;
        logic [PERIOD_W-1:0] period_now;
    } res_beat_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] min_period;
        logic [PERIOD_W-1:0] max_period;
        logic [STEPS_W-1:0]  countdown_steps;
    } cfg_t;

    typedef logic [COILS_W-1:0] coil_row_t [8];

    localparam coil_row_t FULL_ROW = '{4'h3, 4'h3, 4'h6, 4'h6, 4'hC, 4'hC, 4'h9, 4'h9};
    localparam coil_row_t HALF_ROW = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};
    localparam coil_row_t WAVE_ROW = '{4'h1, 4'h1, 4'h2, 4'h2, 4'h4, 4'h4, 4'h8, 4'h8};
    localparam coil_row_t GAP_ROW  = '{4'h1, 4'h0, 4'h2, 4'h0, 4'h4, 4'h0, 4'h8, 4'h0};

    function automatic logic [COILS_W-1:0] coil_pick(
        input logic [PAT_W-1:0]   pat,
        input logic [PHASE_W-1:0] ph
    );
        logic [COILS_W-1:0] levels;
        case (pat)
            PAT_FULL: levels = FULL_ROW[ph];
            PAT_HALF: levels = HALF_ROW[ph];
            PAT_WAVE: levels = WAVE_ROW[ph];
            PAT_GAP:  levels = GAP_ROW[ph];
            default:  levels = '0;
        endcase
        return levels;
    endfunction

endpackage

>>> hdl/sps_apb_regs.sv
// APB configuration registers: period limits and countdown length.
module sps_apb_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sps_pkg::PADDR_W-1:0]  paddr,
    input  logic [sps_pkg::PDATA_W-1:0]  pwdata,
    output logic [sps_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output sps_pkg::cfg_t                cfg
);
    import sps_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_MIN_PERIOD: cfg_next.min_period      = pwdata[PERIOD_W-1:0];
                REG_MAX_PERIOD: cfg_next.max_period      = pwdata[PERIOD_W-1:0];
                REG_COUNTDOWN:  cfg_next.countdown_steps = pwdata[STEPS_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MIN_PERIOD: prdata = PDATA_W'(cfg_reg.min_period);
            REG_MAX_PERIOD: prdata = PDATA_W'(cfg_reg.max_period);
            REG_COUNTDOWN:  prdata = PDATA_W'(cfg_reg.countdown_steps);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_period      <= MIN_PERIOD_RST;
            cfg_reg.max_period      <= MAX_PERIOD_RST;
            cfg_reg.countdown_steps <= COUNTDOWN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/sps_period_calc.sv
// Period scaling by 5/6 and 6/5 through reciprocal multiplies, clamped to the limits.
module sps_period_calc (
    input  logic [sps_pkg::PERIOD_W-1:0] period,
    input  sps_pkg::cfg_t                cfg,
    output logic [sps_pkg::PERIOD_W-1:0] faster_period,
    output logic [sps_pkg::PERIOD_W-1:0] slower_period
);
    import sps_pkg::*;

    localparam int FAST_PROD_W = PERIOD_W + FAST_MUL_W;
    localparam int SLOW_PROD_W = PERIOD_W + SLOW_MUL_W;

    logic [FAST_PROD_W-1:0] fast_prod;
    logic [SLOW_PROD_W-1:0] slow_prod;
    logic [PERIOD_W-1:0]    fast_quot;
    logic [PERIOD_W:0]      slow_quot;

    assign fast_prod = FAST_PROD_W'(period) * FAST_PROD_W'(FAST_MUL);
    assign slow_prod = SLOW_PROD_W'(period) * SLOW_PROD_W'(SLOW_MUL);
    assign fast_quot = fast_prod[MUL_SHIFT +: PERIOD_W];
    assign slow_quot = slow_prod[MUL_SHIFT +: PERIOD_W+1];

    assign faster_period = (fast_quot < cfg.min_period) ? cfg.min_period : fast_quot;
    assign slower_period = (slow_quot > {1'b0, cfg.max_period}) ? cfg.max_period
                                                                : slow_quot[PERIOD_W-1:0];

endmodule

>>> hdl/stepper_phase_sequencer_core.sv
// Top level of the stepper phase sequencer: beat registers, sequencing state and result.
//
// Each beat on the command channel is a microsecond tick or a command; each yields exactly one
// result beat carrying the coil levels, a stepped flag and the current step period. A command
// beat is captured in an input register, evaluated against the sequencing state, and its result
// lands in an output register. One beat is accepted every cycle as long as the result side keeps
// up; a stalled result holds the input register, which then stalls the command side. Throughput
// is set by the single state-update stage, whose longest path is the period scaling multiply and
// clamp. Configuration writes go through the APB port; the user must make them only while no beat
// is in flight, as the block itself does not enforce this.
module stepper_phase_sequencer_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sps_pkg::PADDR_W-1:0]  paddr,
    input  logic [sps_pkg::PDATA_W-1:0]  pwdata,
    output logic [sps_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  sps_pkg::cmd_beat_t           cmd_beat,
    output logic                         res_valid,
    input  logic                         res_stall,
    output sps_pkg::res_beat_t           res_beat
);
    import sps_pkg::*;

    cfg_t                cfg;
    logic [PERIOD_W-1:0] faster_period;
    logic [PERIOD_W-1:0] slower_period;

    logic                cmd_full_reg;
    logic                cmd_full_next;
    cmd_beat_t           cmd_hold_reg;
    logic                res_valid_reg;
    logic                res_valid_next;
    res_beat_t           res_beat_reg;
    res_beat_t           res_beat_next;

    logic [COILS_W-1:0]  coil_levels_reg, coil_levels_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [PAT_W-1:0]    pattern_reg, pattern_next;
    logic                going_forward_reg, going_forward_next;
    logic [PERIOD_W-1:0] step_period_reg, step_period_next;
    logic [STEPS_W-1:0]  steps_left_reg, steps_left_next;
    logic [PERIOD_W-1:0] tick_count_reg, tick_count_next;

    logic                advance;
    logic                take;
    logic [PERIOD_W-1:0] tick_inc;
    logic                step_now;
    logic [STEPS_W-1:0]  steps_dec;

    sps_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sps_period_calc u_period (
        .period        (step_period_reg),
        .cfg           (cfg),
        .faster_period (faster_period),
        .slower_period (slower_period)
    );

    assign advance   = cmd_full_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall = cmd_full_reg && !advance;
    assign take      = cmd_valid && !cmd_stall;

    assign cmd_full_next  = take || (cmd_full_reg && !advance);
    assign res_valid_next = advance || (res_valid_reg && res_stall);

    assign tick_inc  = tick_count_reg + 1'b1;
    assign step_now  = (cmd_hold_reg.cmd == CMD_TICK) && (tick_inc >= step_period_reg);
    assign steps_dec = steps_left_reg - 1'b1;

    always_comb
    begin
        coil_levels_next   = coil_levels_reg;
        phase_next         = phase_reg;
        pattern_next       = pattern_reg;
        going_forward_next = going_forward_reg;
        step_period_next   = step_period_reg;
        steps_left_next    = steps_left_reg;
        tick_count_next    = '0;

        case (cmd_hold_reg.cmd)
            CMD_TICK:
            begin
                if (step_now)
                begin
                    coil_levels_next = coil_pick(pattern_reg, phase_reg);
                    phase_next = going_forward_reg ? phase_reg + 1'b1 : phase_reg - 1'b1;
                    if (steps_left_reg != '0)
                    begin
                        steps_left_next = steps_dec;
                        if (steps_dec == '0)
                        begin
                            pattern_next = PAT_OFF;
                        end
                    end
                end
                else
                begin
                    tick_count_next = tick_inc;
                end
            end
            CMD_SELECT:
            begin
                if (cmd_hold_reg.pattern_select >= PAT_FULL &&
                    cmd_hold_reg.pattern_select <= PAT_GAP)
                begin
                    pattern_next = cmd_hold_reg.pattern_select;
                end
            end
            CMD_FASTER:  step_period_next   = faster_period;
            CMD_SLOWER:  step_period_next   = slower_period;
            CMD_REVERSE: going_forward_next = !going_forward_reg;
            CMD_ARM:     steps_left_next    = cfg.countdown_steps;
            CMD_STOP:    pattern_next       = PAT_OFF;
            default:     pattern_next       = pattern_reg;
        endcase

        res_beat_next.coils      = coil_levels_next;
        res_beat_next.stepped    = step_now;
        res_beat_next.period_now = step_period_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_full_reg      <= 1'b0;
            res_valid_reg     <= 1'b0;
            coil_levels_reg   <= '0;
            phase_reg         <= '0;
            pattern_reg       <= PAT_OFF;
            going_forward_reg <= 1'b1;
            step_period_reg   <= MAX_PERIOD_RST;
            steps_left_reg    <= '0;
            tick_count_reg    <= '0;
        end
        else
        begin
            cmd_full_reg  <= cmd_full_next;
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                coil_levels_reg   <= coil_levels_next;
                phase_reg         <= phase_next;
                pattern_reg       <= pattern_next;
                going_forward_reg <= going_forward_next;
                step_period_reg   <= step_period_next;
                steps_left_reg    <= steps_left_next;
                tick_count_reg    <= tick_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_hold_reg <= cmd_beat;
        end
        if (advance)
        begin
            res_beat_reg <= res_beat_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_beat  = res_beat_reg;

    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd_stall |-> cmd_full_reg && res_valid_reg && res_stall
    ) else $error("command side stalled without a held beat blocked downstream");

    a_step_clears_ticks: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_beat_reg.stepped |-> tick_count_reg == '0
    ) else $error("stepped result left a nonzero tick count");

    a_period_matches: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> res_beat_reg.period_now == step_period_reg
    ) else $error("reported period differs from step period");

    a_coils_match: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> res_beat_reg.coils == coil_levels_reg
    ) else $error("reported coils differ from coil state");

    a_pattern_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        pattern_reg <= PAT_GAP
    ) else $error("pattern out of range");

endmodule

>>> test/tb_stepper_phase_sequencer_core.sv
// Self-checking testbench for the stepper phase sequencer core with its own sequencing predictor.
module tb_stepper_phase_sequencer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import sps_pkg::*;

    localparam logic [CMD_W-1:0]    CMD_UNUSED = 3'd7;
    localparam logic [PERIOD_W-1:0] PERIOD_TOP = 19'h7FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                cmd_valid = 1'b0;
    logic                cmd_stall;
    cmd_beat_t           cmd_beat = '0;
    logic                res_valid;
    logic                res_stall = 1'b0;
    res_beat_t           res_beat;

    stepper_phase_sequencer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_beat  (cmd_beat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_beat  (res_beat)
    );

    always #1 clk = ~clk;

    cmd_beat_t cmd_pending_q [$];
    res_beat_t expected_drive_q [$];
    int        mismatch_count = 0;
    logic      idle_en = 1'b1;
    logic      hold_off = 1'b0;
    int        send_gap = 0;
    int        stall_gap = 0;

    logic [PERIOD_W-1:0] cfg_min_period = MIN_PERIOD_RST;
    logic [PERIOD_W-1:0] cfg_max_period = MAX_PERIOD_RST;
    logic [STEPS_W-1:0]  cfg_countdown = COUNTDOWN_RST;

    logic [COILS_W-1:0]  coil_lvl = '0;
    logic [PHASE_W-1:0]  seq_phase = '0;
    logic [PAT_W-1:0]    seq_pattern = PAT_OFF;
    logic                going_fwd = 1'b1;
    logic [PERIOD_W-1:0] step_per = MAX_PERIOD_RST;
    logic [STEPS_W-1:0]  steps_left = '0;
    logic [PERIOD_W-1:0] tick_cnt = '0;

    logic [COILS_W-1:0] coil_tbl [5][8] = '{
        '{4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0},
        '{4'h3, 4'h3, 4'h6, 4'h6, 4'hC, 4'hC, 4'h9, 4'h9},
        '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9},
        '{4'h1, 4'h1, 4'h2, 4'h2, 4'h4, 4'h4, 4'h8, 4'h8},
        '{4'h1, 4'h0, 4'h2, 4'h0, 4'h4, 4'h0, 4'h8, 4'h0}
    };

    function automatic res_beat_t sequence_beat(input cmd_beat_t b);
        res_beat_t   r;
        logic [31:0] scaled;
        logic        fired;
        fired = 1'b0;
        if (b.cmd == CMD_TICK) begin
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= step_per) begin
                tick_cnt = '0;
                fired = 1'b1;
                coil_lvl = coil_tbl[seq_pattern][seq_phase];
                seq_phase = going_fwd ? seq_phase + 1'b1 : seq_phase - 1'b1;
                if (steps_left != '0) begin
                    steps_left = steps_left - 1'b1;
                    if (steps_left == '0)
                        seq_pattern = PAT_OFF;
                end
            end
        end else begin
            tick_cnt = '0;
            case (b.cmd)
                CMD_SELECT:
                    if (b.pattern_select >= PAT_FULL && b.pattern_select <= PAT_GAP)
                        seq_pattern = b.pattern_select;
                CMD_FASTER: begin
                    scaled = {13'b0, step_per} * 5 / 6;
                    if (scaled < {13'b0, cfg_min_period})
                        scaled = {13'b0, cfg_min_period};
                    step_per = scaled[PERIOD_W-1:0];
                end
                CMD_SLOWER: begin
                    scaled = {13'b0, step_per} * 6 / 5;
                    if (scaled > {13'b0, cfg_max_period})
                        scaled = {13'b0, cfg_max_period};
                    if (scaled > {13'b0, PERIOD_TOP})
                        scaled = {13'b0, PERIOD_TOP};
                    step_per = scaled[PERIOD_W-1:0];
                end
                CMD_REVERSE: going_fwd = ~going_fwd;
                CMD_ARM:     steps_left = cfg_countdown;
                CMD_STOP:    seq_pattern = PAT_OFF;
                default: ;
            endcase
        end
        r.coils = coil_lvl;
        r.stepped = fired;
        r.period_now = step_per;
        return r;
    endfunction

    function automatic cmd_beat_t beat_of(input logic [CMD_W-1:0] c, input logic [PAT_W-1:0] s);
        cmd_beat_t b;
        b.cmd = c;
        b.pattern_select = s;
        return b;
    endfunction

    function automatic cmd_beat_t random_beat();
        cmd_beat_t b;
        if ($urandom_range(0, 99) < 72)
            b.cmd = CMD_TICK;
        else
            b.cmd = CMD_W'($urandom_range(1, 7));
        b.pattern_select = PAT_W'($urandom_range(0, 7));
        return b;
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned want, input int unsigned got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch: expected %0d, actual %0d", $realtime, what, want, got);
    endtask

    // Sender: hold a stalled beat, otherwise advance through the pending queue with random idle gaps.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cmd_valid <= 1'b0;
            cmd_beat <= '0;
            send_gap <= 0;
        end else begin
            if (cmd_valid && !cmd_stall)
                expected_drive_q.push_back(sequence_beat(cmd_beat));
            if (!cmd_valid || !cmd_stall) begin
                if (send_gap > 0) begin
                    cmd_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (cmd_pending_q.size() != 0) begin
                    if (idle_en && $urandom_range(0, 11) == 0) begin
                        cmd_valid <= 1'b0;
                        send_gap <= $urandom_range(1, 14) - 1;
                    end else begin
                        cmd_valid <= 1'b1;
                        cmd_beat <= cmd_pending_q.pop_front();
                    end
                end else begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result beat against the oldest expectation and drive random stalls.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res_stall <= 1'b0;
            stall_gap <= 0;
        end else begin
            if (res_valid && !res_stall) begin
                if (expected_drive_q.size() == 0) begin
                    flag_mismatch("unexpected result beat", 0, 1);
                end else begin
                    res_beat_t want;
                    want = expected_drive_q.pop_front();
                    if (res_beat.coils !== want.coils)
                        flag_mismatch("coils", want.coils, res_beat.coils);
                    if (res_beat.stepped !== want.stepped)
                        flag_mismatch("stepped", want.stepped, res_beat.stepped);
                    if (res_beat.period_now !== want.period_now)
                        flag_mismatch("period_now", want.period_now, res_beat.period_now);
                end
            end
            if (hold_off) begin
                res_stall <= 1'b1;
            end else if (stall_gap > 0) begin
                res_stall <= 1'b1;
                stall_gap <= stall_gap - 1;
            end else if (idle_en && $urandom_range(0, 11) == 0) begin
                res_stall <= 1'b1;
                stall_gap <= $urandom_range(1, 14) - 1;
            end else begin
                res_stall <= 1'b0;
            end
        end
    end

    task automatic wait_drained();
        while (cmd_pending_q.size() != 0 || cmd_valid || expected_drive_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MIN_PERIOD: cfg_min_period = val[PERIOD_W-1:0];
            REG_MAX_PERIOD: cfg_max_period = val[PERIOD_W-1:0];
            REG_COUNTDOWN:  cfg_countdown = val[STEPS_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic load_setting(input int unsigned min_p, input int unsigned max_p,
                                input int unsigned steps);
        wait_drained();
        reg_write(REG_MIN_PERIOD, min_p);
        reg_write(REG_MAX_PERIOD, max_p);
        reg_write(REG_COUNTDOWN, steps);
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            cmd_pending_q.push_back(random_beat());
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: every command, selects in and out of range
        cmd_pending_q.push_back(beat_of(CMD_TICK, 3'd0));
        cmd_pending_q.push_back(beat_of(CMD_TICK, 3'd7));
        for (int s = 0; s < 8; s++)
            cmd_pending_q.push_back(beat_of(CMD_SELECT, PAT_W'(s)));
        cmd_pending_q.push_back(beat_of(CMD_UNUSED, 3'd7));
        cmd_pending_q.push_back(beat_of(CMD_REVERSE, 3'd0));
        cmd_pending_q.push_back(beat_of(CMD_ARM, 3'd0));
        cmd_pending_q.push_back(beat_of(CMD_STOP, 3'd0));
        cmd_pending_q.push_back(beat_of(CMD_FASTER, 3'd0));
        cmd_pending_q.push_back(beat_of(CMD_SLOWER, 3'd0));
        cmd_pending_q.push_back(beat_of(CMD_REVERSE, 3'd0));
        cmd_pending_q.push_back(beat_of(CMD_TICK, 3'd0));

        // short periods and a countdown that runs out
        load_setting(1, 6, 9);
        cmd_pending_q.push_back(beat_of(CMD_SLOWER, 3'd0));
        cmd_pending_q.push_back(beat_of(CMD_SELECT, PAT_FULL));
        queue_random(200);
        repeat (20) @(negedge clk);
        hold_off = 1'b1;
        repeat (60) @(negedge clk);
        hold_off = 1'b0;

        // zero period steps on every tick, zero countdown stays disarmed
        load_setting(0, 3, 0);
        cmd_pending_q.push_back(beat_of(CMD_SLOWER, 3'd0));
        repeat (3) cmd_pending_q.push_back(beat_of(CMD_FASTER, 3'd0));
        cmd_pending_q.push_back(beat_of(CMD_SELECT, PAT_HALF));
        cmd_pending_q.push_back(beat_of(CMD_ARM, 3'd0));
        repeat (4) cmd_pending_q.push_back(beat_of(CMD_TICK, 3'd0));
        queue_random(150);

        // crossed limits, single step countdown
        load_setting(12, 4, 1);
        cmd_pending_q.push_back(beat_of(CMD_SLOWER, 3'd0));
        cmd_pending_q.push_back(beat_of(CMD_FASTER, 3'd0));
        cmd_pending_q.push_back(beat_of(CMD_SLOWER, 3'd0));
        cmd_pending_q.push_back(beat_of(CMD_SELECT, PAT_WAVE));
        queue_random(200);

        // top of every range
        load_setting(PERIOD_TOP, PERIOD_TOP, 8191);
        cmd_pending_q.push_back(beat_of(CMD_FASTER, 3'd0));
        cmd_pending_q.push_back(beat_of(CMD_SLOWER, 3'd0));
        cmd_pending_q.push_back(beat_of(CMD_ARM, 3'd0));
        cmd_pending_q.push_back(beat_of(CMD_SELECT, PAT_GAP));
        queue_random(20);

        // drop idling for the last stretch
        load_setting(2, 20, 37);
        idle_en = 1'b0;
        cmd_pending_q.push_back(beat_of(CMD_SLOWER, 3'd0));
        cmd_pending_q.push_back(beat_of(CMD_SELECT, PAT_GAP));
        queue_random(350);

        wait_drained();
        repeat (10) @(negedge clk);
        if (expected_drive_q.size() != 0)
            flag_mismatch("missing result beats", expected_drive_q.size(), 0);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> files.f
hdl/sps_pkg.sv
hdl/sps_apb_regs.sv
hdl/sps_period_calc.sv
hdl/stepper_phase_sequencer_core.sv
test/tb_stepper_phase_sequencer_core.sv
